### rtl/core/stsl_pkg.sv
// ----------------------------------------------------------------------------
// Symbol timing slicer package
// Shared widths, register indexes, mode codes, FSM states and the structs
// that pass between the slicer modules.
// ----------------------------------------------------------------------------
package stsl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 20;   // worst case is seven full-scale samples
    localparam int CNT_W    = 4;
    localparam int IDX_W    = 7;    // signed sample index, -1 .. 31
    localparam int MAX_SPS  = 32;

    // symbol lengths with their own window rules; the long one also has its own timing rule
    localparam logic [5:0] SPS_LONG  = 6'd20;
    localparam logic [5:0] SPS_SHORT = 6'd5;

    localparam logic signed [7:0] LONG_EARLY_LO = 8'sd7;
    localparam logic signed [7:0] LONG_EARLY_HI = 8'sd10;
    localparam logic signed [7:0] LONG_LATE_LO  = 8'sd11;
    localparam logic signed [7:0] LONG_LATE_HI  = 8'sd14;
    localparam logic signed [7:0] LONG_WIN_LO   = 8'sd9;
    localparam logic signed [7:0] LONG_WIN_HI   = 8'sd11;
    localparam logic signed [7:0] SHORT_WIN_IDX = 8'sd2;

    localparam logic [1:0] MOD_C4FM = 2'd0;
    localparam logic [1:0] MOD_QPSK = 2'd1;
    localparam logic [1:0] MOD_GFSK = 2'd2;

    typedef enum logic [2:0] {
        REG_SPS,
        REG_CENTER_IDX,
        REG_MODULATION,
        REG_CLAMP_HIGH,
        REG_CLAMP_LOW,
        REG_CENTER_LEVEL,
        REG_HIGH_REF,
        REG_LOW_REF
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_LAUNCH,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [5:0]          sps;
        logic [4:0]          center_idx;
        logic [1:0]          modulation;
        logic signed [15:0]  clamp_high;
        logic signed [15:0]  clamp_low;
        logic signed [15:0]  center_level;
        logic signed [15:0]  high_ref;
        logic signed [15:0]  low_ref;
    } cfg_t;

    typedef struct packed {
        logic                     sym_end;
        logic signed [SUM_W-1:0]  window_sum;
        logic [CNT_W-1:0]         window_count;
        logic [15:0]              crossing_count;
        logic signed [IDX_W-1:0]  edge_index;
        logic [15:0]              symbol_counter;
    } track_status_t;

endpackage

### rtl/core/stsl_divider.sv
// ----------------------------------------------------------------------------
// Window average divider
// Signed truncating division of the window sum by the sample count, one
// quotient bit per cycle on the magnitude with a shared subtractor.
// ----------------------------------------------------------------------------
module stsl_divider
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [stsl_pkg::SUM_W-1:0]      dividend,
    input  logic [stsl_pkg::CNT_W-1:0]             divisor,
    output logic                                   busy,
    output logic                                   done,
    output logic signed [stsl_pkg::SAMPLE_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(stsl_pkg::SUM_W);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [STEP_W-1:0]              cnt_reg, cnt_next;
    logic [stsl_pkg::SUM_W-1:0]     quo_reg, quo_next;
    logic [stsl_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [stsl_pkg::CNT_W-1:0]     div_reg, div_next;
    logic                           neg_reg, neg_next;

    logic [stsl_pkg::CNT_W-1:0]     trial;
    logic                           fits;

    // remainder stays below the divisor, so its top bit is always clear
    assign trial = {rem_reg[stsl_pkg::CNT_W-2:0], quo_reg[stsl_pkg::SUM_W-1]};
    assign fits  = (trial >= div_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            div_next  = divisor;
            neg_next  = dividend[stsl_pkg::SUM_W-1];
            quo_next  = dividend[stsl_pkg::SUM_W-1] ? stsl_pkg::SUM_W'(-dividend)
                                                     : stsl_pkg::SUM_W'(dividend);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - div_reg) : trial;
            quo_next = {quo_reg[stsl_pkg::SUM_W-2:0], fits};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(stsl_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg[stsl_pkg::SAMPLE_W-1:0])
                              : $signed(quo_reg[stsl_pkg::SAMPLE_W-1:0]);

endmodule

### rtl/core/stsl_track.sv
// ----------------------------------------------------------------------------
// Symbol tracker
// Per-sample timing state: start-of-symbol adjustment, clamping, level
// crossing count, first edge index and window accumulation.
// ----------------------------------------------------------------------------
module stsl_track
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step,
    input  stsl_pkg::cfg_t                        cfg,
    input  logic signed [stsl_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  frame_sync,
    output stsl_pkg::track_status_t               status
);

    localparam int IW = stsl_pkg::IDX_W;
    localparam int SW = stsl_pkg::SUM_W;

    logic signed [IW-1:0]                  sample_index_reg, sample_index_next;
    logic                                  symbol_active_reg, symbol_active_next;
    logic                                  sync_latched_reg, sync_latched_next;
    logic signed [IW-1:0]                  edge_index_reg, edge_index_next;
    logic signed [SW-1:0]                  window_sum_reg, window_sum_next;
    logic [stsl_pkg::CNT_W-1:0]            window_count_reg, window_count_next;
    logic signed [stsl_pkg::SAMPLE_W-1:0]  prev_reg, prev_next;
    logic [15:0]                           crossing_reg, crossing_next;
    logic [15:0]                           symbol_counter_reg, symbol_counter_next;

    logic [5:0]                            sps_eff;
    logic signed [7:0]                     sps_s, c_s, j_s, idx_start, idx;
    logic                                  start, sync_now, sym_end;
    logic signed [IW-1:0]                  edge_cur;
    logic signed [stsl_pkg::SAMPLE_W-1:0]  s;
    logic signed [SW-1:0]                  s4, p4, hi5, lo5, s20, sum_base;
    logic [stsl_pkg::CNT_W-1:0]            cnt_base;
    logic                                  above, prev_lt, prev_gt;
    logic                                  cross_c, cross_o, edge_set;
    logic                                  add_a, add_b;

    assign sps_eff = (cfg.sps > 6'(stsl_pkg::MAX_SPS)) ? 6'(stsl_pkg::MAX_SPS) : cfg.sps;
    assign sps_s   = $signed({2'b00, sps_eff});
    assign c_s     = $signed({3'b000, cfg.center_idx});
    assign j_s     = {edge_index_reg[IW-1], edge_index_reg};

    assign start    = !symbol_active_reg;
    assign sync_now = start ? frame_sync : sync_latched_reg;

    // timing nudge from the previous symbol's first edge
    always_comb
    begin
        idx_start = 8'sd0;
        if (!frame_sync)
        begin
            priority if (sps_eff == stsl_pkg::SPS_LONG)
            begin
                if (j_s >= stsl_pkg::LONG_EARLY_LO && j_s <= stsl_pkg::LONG_EARLY_HI)
                    idx_start = -8'sd1;
                else if (j_s >= stsl_pkg::LONG_LATE_LO && j_s <= stsl_pkg::LONG_LATE_HI)
                    idx_start = 8'sd1;
            end
            else if (cfg.modulation == stsl_pkg::MOD_GFSK)
            begin
                if (j_s >= c_s - 8'sd1 && j_s <= c_s)
                    idx_start = -8'sd1;
                else if (j_s >= c_s + 8'sd1 && j_s <= c_s + 8'sd2)
                    idx_start = 8'sd1;
            end
            else if (cfg.modulation == stsl_pkg::MOD_C4FM)
            begin
                if (j_s > 8'sd0 && j_s <= c_s)
                    idx_start = -8'sd1;
                else if (j_s > c_s && j_s < sps_s)
                    idx_start = 8'sd1;
            end
            else
                idx_start = 8'sd0;
        end
    end

    assign idx      = start ? idx_start : {sample_index_reg[IW-1], sample_index_reg};
    assign edge_cur = (start && !frame_sync) ? -IW'(1) : edge_index_reg;

    // clamp only while synced in C4FM; upper test wins on inverted limits
    always_comb
    begin
        s = sample;
        if (sync_now && cfg.modulation == stsl_pkg::MOD_C4FM)
        begin
            if (sample > cfg.clamp_high)
                s = cfg.clamp_high;
            else if (sample < cfg.clamp_low)
                s = cfg.clamp_low;
        end
    end

    // 1.25 * ref compared exactly as 4*s against 5*ref
    assign s20 = SW'(s);
    assign s4  = s20 <<< 2;
    assign p4  = SW'(prev_reg) <<< 2;
    assign hi5 = (SW'(cfg.high_ref) <<< 2) + SW'(cfg.high_ref);
    assign lo5 = (SW'(cfg.low_ref) <<< 2) + SW'(cfg.low_ref);

    assign above   = (s > cfg.center_level);
    assign prev_lt = (prev_reg < cfg.center_level);
    assign prev_gt = (prev_reg > cfg.center_level);

    always_comb
    begin
        if (above)
        begin
            cross_c  = prev_lt;
            cross_o  = (s4 > hi5) && (p4 < hi5);
            edge_set = !(s4 > hi5) && edge_cur[IW-1] && prev_lt;
        end
        else
        begin
            cross_c  = prev_gt;
            cross_o  = (s4 < lo5) && (p4 > lo5);
            edge_set = !(s4 < lo5) && edge_cur[IW-1] && prev_gt;
        end
    end

    // averaging windows
    always_comb
    begin
        add_a = (sps_eff == stsl_pkg::SPS_LONG) && (idx >= stsl_pkg::LONG_WIN_LO)
                && (idx <= stsl_pkg::LONG_WIN_HI);
        priority if (sps_eff == stsl_pkg::SPS_SHORT)
            add_b = (idx == stsl_pkg::SHORT_WIN_IDX);
        else if (cfg.modulation != stsl_pkg::MOD_QPSK)
            add_b = (idx >= c_s - 8'sd1) && (idx <= c_s + 8'sd2);
        else
            add_b = (idx == c_s - 8'sd1) || (idx == c_s + 8'sd1);
    end

    assign sum_base = start ? '0 : window_sum_reg;
    assign cnt_base = start ? '0 : window_count_reg;
    assign sym_end  = (idx + 8'sd1) >= sps_s;

    always_comb
    begin
        sample_index_next   = sample_index_reg;
        symbol_active_next  = symbol_active_reg;
        sync_latched_next   = sync_latched_reg;
        edge_index_next     = edge_index_reg;
        window_sum_next     = window_sum_reg;
        window_count_next   = window_count_reg;
        prev_next           = prev_reg;
        crossing_next       = crossing_reg;
        symbol_counter_next = symbol_counter_reg;
        if (step)
        begin
            sync_latched_next = sync_now;
            edge_index_next   = edge_set ? idx[IW-1:0] : edge_cur;
            window_sum_next   = sum_base + (add_a ? s20 : SW'(0)) + (add_b ? s20 : SW'(0));
            window_count_next = cnt_base + stsl_pkg::CNT_W'(add_a)
                                + stsl_pkg::CNT_W'(add_b);
            prev_next         = s;
            crossing_next     = crossing_reg + 16'(cross_c) + 16'(cross_o);
            if (sym_end)
            begin
                symbol_active_next  = 1'b0;
                sample_index_next   = '0;
                symbol_counter_next = symbol_counter_reg + 16'd1;
            end
            else
            begin
                symbol_active_next = 1'b1;
                sample_index_next  = idx[IW-1:0] + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg   <= '0;
            symbol_active_reg  <= 1'b0;
            sync_latched_reg   <= 1'b0;
            edge_index_reg     <= -IW'(1);
            window_sum_reg     <= '0;
            window_count_reg   <= '0;
            prev_reg           <= '0;
            crossing_reg       <= '0;
            symbol_counter_reg <= '0;
        end
        else
        begin
            sample_index_reg   <= sample_index_next;
            symbol_active_reg  <= symbol_active_next;
            sync_latched_reg   <= sync_latched_next;
            edge_index_reg     <= edge_index_next;
            window_sum_reg     <= window_sum_next;
            window_count_reg   <= window_count_next;
            prev_reg           <= prev_next;
            crossing_reg       <= crossing_next;
            symbol_counter_reg <= symbol_counter_next;
        end
    end

    always_comb
    begin
        status.sym_end        = step && sym_end;
        status.window_sum     = window_sum_reg;
        status.window_count   = window_count_reg;
        status.crossing_count = crossing_reg;
        status.edge_index     = edge_index_reg;
        status.symbol_counter = symbol_counter_reg;
    end

endmodule

### rtl/core/symbol_timing_slicer_top.sv
// ----------------------------------------------------------------------------
// Symbol timing slicer, top level
// Sequencer, configuration registers, result register and the tracker and
// divider instances.
// ----------------------------------------------------------------------------
// A sample that does not close a symbol is accepted in ST_IDLE and applied
// in ST_STEP. A closing sample goes on through ST_LAUNCH, ST_DIV (20-step
// bit-serial divider of the window average) and ST_EMIT; an empty window
// skips the divider. One sample is in flight at a time; a finished result
// waits in the output register while the next sample is taken.
// Reset (rst_n, async, active low) loads the register defaults and clears
// the symbol state; in_ready is already high when reset is released.
// ----------------------------------------------------------------------------
module symbol_timing_slicer_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   sample,
    input  logic                 frame_sync,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   symbol_value,
    output logic [15:0]          flip_count,
    output logic signed [6:0]    edge_offset,
    output logic [15:0]          symbol_number,
    output logic                 empty_window
);

    stsl_pkg::cfg_t           cfg_reg, cfg_next;
    stsl_pkg::state_t         state_reg, state_next;
    stsl_pkg::track_status_t  status;

    logic signed [15:0]  sample_reg;
    logic                sync_reg;
    logic                out_valid_reg, out_valid_next;
    logic signed [15:0]  symbol_value_reg;
    logic [15:0]         flip_count_reg;
    logic signed [6:0]   edge_offset_reg;
    logic [15:0]         symbol_number_reg;
    logic                empty_window_reg;

    logic                step, div_start, div_busy, div_done, load_out, empty;
    logic signed [15:0]  div_quotient;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (stsl_pkg::reg_idx_t'(cfg_index))
                stsl_pkg::REG_SPS:          cfg_next.sps          = cfg_data[5:0];
                stsl_pkg::REG_CENTER_IDX:   cfg_next.center_idx   = cfg_data[4:0];
                stsl_pkg::REG_MODULATION:   cfg_next.modulation   = cfg_data[1:0];
                stsl_pkg::REG_CLAMP_HIGH:   cfg_next.clamp_high   = $signed(cfg_data);
                stsl_pkg::REG_CLAMP_LOW:    cfg_next.clamp_low    = $signed(cfg_data);
                stsl_pkg::REG_CENTER_LEVEL: cfg_next.center_level = $signed(cfg_data);
                stsl_pkg::REG_HIGH_REF:     cfg_next.high_ref     = $signed(cfg_data);
                stsl_pkg::REG_LOW_REF:      cfg_next.low_ref      = $signed(cfg_data);
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sps          <= 6'd10;
            cfg_reg.center_idx   <= 5'd4;
            cfg_reg.modulation   <= stsl_pkg::MOD_C4FM;
            cfg_reg.clamp_high   <= 16'sh7FFF;
            cfg_reg.clamp_low    <= 16'sh8000;
            cfg_reg.center_level <= '0;
            cfg_reg.high_ref     <= '0;
            cfg_reg.low_ref      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    stsl_track u_track
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cfg        (cfg_reg),
        .sample     (sample_reg),
        .frame_sync (sync_reg),
        .status     (status)
    );

    stsl_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (status.window_sum),
        .divisor  (status.window_count),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // sequencer
    assign empty = (status.window_count == '0);

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        step       = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            stsl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = stsl_pkg::ST_STEP;
            end
            stsl_pkg::ST_STEP:
            begin
                step       = 1'b1;
                state_next = status.sym_end ? stsl_pkg::ST_LAUNCH : stsl_pkg::ST_IDLE;
            end
            stsl_pkg::ST_LAUNCH:
            begin
                div_start  = !empty;
                state_next = empty ? stsl_pkg::ST_EMIT : stsl_pkg::ST_DIV;
            end
            stsl_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = stsl_pkg::ST_EMIT;
            end
            stsl_pkg::ST_EMIT:
            begin
                load_out = !out_valid_reg || out_ready;
                if (load_out)
                    state_next = stsl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = stsl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stsl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= sample;
            sync_reg   <= frame_sync;
        end
        if (load_out)
        begin
            symbol_value_reg  <= empty ? 16'sd0 : div_quotient;
            flip_count_reg    <= status.crossing_count;
            edge_offset_reg   <= status.edge_index;
            symbol_number_reg <= status.symbol_counter;
            empty_window_reg  <= empty;
        end
    end

    assign out_valid     = out_valid_reg;
    assign symbol_value  = symbol_value_reg;
    assign flip_count    = flip_count_reg;
    assign edge_offset   = edge_offset_reg;
    assign symbol_number = symbol_number_reg;
    assign empty_window  = empty_window_reg;

    // checks
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second sample taken while one is in flight");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == stsl_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_window) |-> (symbol_value == 16'sd0))
        else $error("empty window with non-zero symbol value");

endmodule

### tb/sv/tb_symbol_timing_slicer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol timing slicer testbench
// Feeds shaped samples through the valid/ready input, keeps its own copy of
// the slicer state to predict every symbol, and checks each symbol that
// leaves the block field by field. Directed cases first, then shaped random
// symbols over many register settings, output back-pressure and a stream
// with no idling.
// ----------------------------------------------------------------------------
module tb_symbol_timing_slicer_top;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 40;    // room for a closing sample to pass the divider
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 1100;
    localparam int STREAM_ITEMS    = 200;
    localparam int MIN_SYMBOLS     = 60;
    localparam int MAX_PRINTED     = 40;
    localparam int SPS_FIELD_MAX   = 63;
    localparam logic [1:0] MOD_SPARE = 2'd3;

    typedef struct packed {
        logic signed [15:0] value;
        logic [15:0]        flips;
        logic signed [6:0]  edge_off;
        logic [15:0]        number;
        logic               empty;
    } symbol_result_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_write  = 1'b0;
    logic [2:0]         cfg_index  = stsl_pkg::REG_SPS;
    logic [15:0]        cfg_data   = '0;
    logic               in_valid   = 1'b0;
    logic signed [15:0] sample     = '0;
    logic               frame_sync = 1'b0;
    logic               out_ready  = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic signed [15:0] symbol_value;
    logic [15:0]        flip_count;
    logic signed [6:0]  edge_offset;
    logic [15:0]        symbol_number;
    logic               empty_window;

    symbol_timing_slicer_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .frame_sync    (frame_sync),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .symbol_value  (symbol_value),
        .flip_count    (flip_count),
        .edge_offset   (edge_offset),
        .symbol_number (symbol_number),
        .empty_window  (empty_window)
    );

    always #CLK_HALF clk = ~clk;

    // slicer state as the block should hold it
    stsl_pkg::cfg_t cfg;
    int          slot         = 0;
    bit          in_symbol    = 1'b0;
    bit          sync_held    = 1'b0;
    int          first_edge   = -1;
    int          win_sum      = 0;
    int          win_cnt      = 0;
    int          last_sample  = 0;
    logic [15:0] flips        = '0;
    logic [15:0] symbols_done = '0;

    symbol_result_t expected_symbols[$];

    int items_sent        = 0;
    int symbols_predicted = 0;
    int mismatch_count    = 0;
    int idle_cycles       = 0;
    int stall_left        = 0;
    int hold_request      = 0;
    bit idle_en           = 1'b1;

    // stimulus shaping
    int symbol_level = 0;
    int ramp_len     = 0;
    bit sync_state   = 1'b0;

    function automatic stsl_pkg::cfg_t make_cfg(input int sps, input int centre,
                                                input logic [1:0] mode,
                                                input int ch, input int cl, input int ctr,
                                                input int hr, input int lr);
        stsl_pkg::cfg_t c;
        c.sps          = 6'(sps);
        c.center_idx   = 5'(centre);
        c.modulation   = mode;
        c.clamp_high   = 16'(ch);
        c.clamp_low    = 16'(cl);
        c.center_level = 16'(ctr);
        c.high_ref     = 16'(hr);
        c.low_ref      = 16'(lr);
        return c;
    endfunction

    // One accepted sample; queues a symbol when it closes one.
    function automatic void slice_sample(input logic signed [15:0] smp, input logic sync_in);
        int s;
        int sps;
        int c;
        int ctr;
        int hi5;
        int lo5;
        int i;
        symbol_result_t r;
        s   = smp;
        sps = (cfg.sps > stsl_pkg::MAX_SPS) ? stsl_pkg::MAX_SPS : cfg.sps;
        c   = cfg.center_idx;
        ctr = $signed(cfg.center_level);
        hi5 = 5 * $signed(cfg.high_ref);
        lo5 = 5 * $signed(cfg.low_ref);

        if (!in_symbol)
        begin
            in_symbol = 1'b1;
            sync_held = sync_in;
            win_sum   = 0;
            win_cnt   = 0;
            slot      = 0;
            if (!sync_held)
            begin
                if (sps == stsl_pkg::SPS_LONG)
                begin
                    if (first_edge >= stsl_pkg::LONG_EARLY_LO
                        && first_edge <= stsl_pkg::LONG_EARLY_HI)
                        slot = -1;
                    else if (first_edge >= stsl_pkg::LONG_LATE_LO
                             && first_edge <= stsl_pkg::LONG_LATE_HI)
                        slot = 1;
                end
                else if (cfg.modulation == stsl_pkg::MOD_GFSK)
                begin
                    if (first_edge >= c - 1 && first_edge <= c)
                        slot = -1;
                    else if (first_edge >= c + 1 && first_edge <= c + 2)
                        slot = 1;
                end
                else if (cfg.modulation == stsl_pkg::MOD_C4FM)
                begin
                    if (first_edge > 0 && first_edge <= c)
                        slot = -1;
                    else if (first_edge > c && first_edge < sps)
                        slot = 1;
                end
                first_edge = -1;
            end
        end
        i = slot;

        // upper bound wins when the clamps are inverted
        if (sync_held && cfg.modulation == stsl_pkg::MOD_C4FM)
        begin
            if (s > $signed(cfg.clamp_high))
                s = $signed(cfg.clamp_high);
            else if (s < $signed(cfg.clamp_low))
                s = $signed(cfg.clamp_low);
        end

        if (s > ctr)
        begin
            if (last_sample < ctr)
                flips++;
            if (4 * s > hi5)
            begin
                if (4 * last_sample < hi5)
                    flips++;
            end
            else if (first_edge < 0 && last_sample < ctr)
                first_edge = i;
        end
        else
        begin
            if (last_sample > ctr)
                flips++;
            if (4 * s < lo5)
            begin
                if (4 * last_sample > lo5)
                    flips++;
            end
            else if (first_edge < 0 && last_sample > ctr)
                first_edge = i;
        end

        if (sps == stsl_pkg::SPS_LONG && i >= stsl_pkg::LONG_WIN_LO
            && i <= stsl_pkg::LONG_WIN_HI)
        begin
            win_sum += s;
            win_cnt++;
        end
        if (sps == stsl_pkg::SPS_SHORT)
        begin
            if (i == stsl_pkg::SHORT_WIN_IDX)
            begin
                win_sum += s;
                win_cnt++;
            end
        end
        else if (cfg.modulation != stsl_pkg::MOD_QPSK)
        begin
            if (i >= c - 1 && i <= c + 2)
            begin
                win_sum += s;
                win_cnt++;
            end
        end
        else if (i == c - 1 || i == c + 1)
        begin
            win_sum += s;
            win_cnt++;
        end
        last_sample = s;

        if (i + 1 < sps)
        begin
            slot = i + 1;
            return;
        end

        in_symbol = 1'b0;
        slot      = 0;
        symbols_done++;
        r.empty    = (win_cnt == 0);
        r.value    = (win_cnt == 0) ? 16'sd0 : 16'(win_sum / win_cnt);
        r.flips    = flips;
        r.edge_off = 7'(first_edge);
        r.number   = symbols_done;
        expected_symbols.push_back(r);
        symbols_predicted++;
    endfunction

    // Mostly symbol-shaped levels around the references, with a ramp at the
    // start of each symbol so edges land on varying indices.
    function automatic logic signed [15:0] stimulus_sample(input int noise_pct);
        int hr;
        int lr;
        int ctr;
        int span;
        int v;
        hr  = $signed(cfg.high_ref);
        lr  = $signed(cfg.low_ref);
        ctr = $signed(cfg.center_level);
        if ($urandom_range(0, 99) < noise_pct)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return 16'($urandom);
            endcase
        end
        if (!in_symbol)
        begin
            case ($urandom_range(0, 3))
                0:       symbol_level = hr + hr / 2;
                1:       symbol_level = (ctr + hr) / 2;
                2:       symbol_level = (ctr + lr) / 2;
                default: symbol_level = lr + lr / 2;
            endcase
            ramp_len = $urandom_range(0, 3);
        end
        span = (hr > lr ? hr - lr : lr - hr) / 16 + 1;
        v = symbol_level + int'($urandom_range(0, 2 * span)) - span;
        if (slot < ramp_len)
            v = (v + last_sample) / 2;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    // sync mostly comes in long runs, now and then a stray value
    function automatic logic next_sync();
        if ($urandom_range(0, 24) == 0)
            sync_state = ~sync_state;
        return ($urandom_range(0, 19) == 0) ? ~sync_state : sync_state;
    endfunction

    function automatic stsl_pkg::cfg_t random_cfg(input int phase);
        int sps;
        int centre;
        int ch;
        int cl;
        int ctr;
        int hr;
        int lr;
        logic [1:0] mode;
        case (phase)
            0:       sps = SPS_FIELD_MAX;
            1:       sps = stsl_pkg::SPS_LONG;
            2:       sps = stsl_pkg::SPS_SHORT;
            default:
                case ($urandom_range(0, 9))
                    0:       sps = $urandom_range(0, 1);
                    1:       sps = $urandom_range(21, SPS_FIELD_MAX);
                    2:       sps = stsl_pkg::SPS_LONG;
                    3:       sps = stsl_pkg::SPS_SHORT;
                    default: sps = $urandom_range(2, 12);
                endcase
        endcase
        if ($urandom_range(0, 7) == 0)
            centre = 31;
        else
            centre = $urandom_range(0, (sps > 31) ? 31 : sps);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: mode = stsl_pkg::MOD_C4FM;
            4, 5:       mode = stsl_pkg::MOD_QPSK;
            6, 7, 8:    mode = stsl_pkg::MOD_GFSK;
            default:    mode = MOD_SPARE;
        endcase
        ch = 32767;
        cl = -32768;
        if ($urandom_range(0, 2) == 0)
        begin
            ch = $signed(16'($urandom));
            cl = $signed(16'($urandom));
        end
        if ($urandom_range(0, 4) == 0)
        begin
            ctr = $signed(16'($urandom));
            hr  = $signed(16'($urandom));
            lr  = $signed(16'($urandom));
        end
        else
        begin
            ctr = int'($urandom_range(0, 1000)) - 500;
            hr  = $urandom_range(1000, 20000);
            lr  = -int'($urandom_range(1000, 20000));
        end
        return make_cfg(sps, centre, mode, ch, cl, ctr, hr, lr);
    endfunction

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_symbol();
        symbol_result_t want;
        if (expected_symbols.size() == 0)
        begin
            report_mismatch("unexpected symbol_number", symbol_number, 0);
            return;
        end
        want = expected_symbols.pop_front();
        if (symbol_value !== want.value)
            report_mismatch("symbol_value", symbol_value, want.value);
        if (flip_count !== want.flips)
            report_mismatch("flip_count", flip_count, want.flips);
        if (edge_offset !== want.edge_off)
            report_mismatch("edge_offset", edge_offset, want.edge_off);
        if (symbol_number !== want.number)
            report_mismatch("symbol_number", symbol_number, want.number);
        if (empty_window !== want.empty)
            report_mismatch("empty_window", empty_window, want.empty);
    endtask

    // result side: check, then pick out_ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            check_symbol();
        if (hold_request > 0)
        begin
            out_ready <= 1'b0;
            hold_request--;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(0, 9);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    task automatic apply_config(input stsl_pkg::cfg_t setting);
        stsl_pkg::reg_idx_t r;
        r = r.first();
        do
        begin
            cfg_write <= 1'b1;
            cfg_index <= r;
            case (r)
                stsl_pkg::REG_SPS:          cfg_data <= 16'(setting.sps);
                stsl_pkg::REG_CENTER_IDX:   cfg_data <= 16'(setting.center_idx);
                stsl_pkg::REG_MODULATION:   cfg_data <= 16'(setting.modulation);
                stsl_pkg::REG_CLAMP_HIGH:   cfg_data <= setting.clamp_high;
                stsl_pkg::REG_CLAMP_LOW:    cfg_data <= setting.clamp_low;
                stsl_pkg::REG_CENTER_LEVEL: cfg_data <= setting.center_level;
                stsl_pkg::REG_HIGH_REF:     cfg_data <= setting.high_ref;
                default:                    cfg_data <= setting.low_ref;
            endcase
            @(posedge clk);
            r = r.next();
        end
        while (r != r.first());
        cfg_write <= 1'b0;
        cfg = setting;
    endtask

    // valid stays up between back-to-back transactions
    task automatic send_sample(input logic signed [15:0] value, input logic sync_in);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        sample     <= value;
        frame_sync <= sync_in;
        do @(posedge clk); while (in_ready !== 1'b1);
        slice_sample(value, sync_in);
        items_sent++;
    endtask

    task automatic finish_symbol();
        while (in_symbol)
            send_sample(stimulus_sample(10), next_sync());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_sample_extremes();
        apply_config(make_cfg(2, 0, stsl_pkg::MOD_C4FM, 32767, -32768, 0, 8000, -8000));
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        // 10000 sits exactly on 1.25 x 8000, 10001 just beyond
        send_sample(16'sd10000, 1'b0);
        send_sample(16'sd10001, 1'b0);
        send_sample(-16'sd10000, 1'b1);
        send_sample(-16'sd10001, 1'b1);
        finish_symbol();
        wait_idle();
    endtask

    task automatic test_sync_and_clamp();
        // inverted clamps, sync only taken on a symbol's first sample
        apply_config(make_cfg(3, 1, stsl_pkg::MOD_C4FM, -100, 100, 0, 1000, -1000));
        send_sample(16'sd5000, 1'b1);
        send_sample(-16'sd5000, 1'b1);
        send_sample(16'sd50, 1'b0);
        send_sample(-16'sd20, 1'b0);
        send_sample(16'sd3000, 1'b1);
        send_sample(-16'sd3000, 1'b1);
        finish_symbol();
        wait_idle();
    endtask

    task automatic test_timing_steps();
        // GFSK with centre 0: no edge steps back, first sample lands in the window
        apply_config(make_cfg(3, 0, stsl_pkg::MOD_GFSK, 32767, -32768, 0, 4000, -4000));
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b0);
        send_sample(16'sd1000, 1'b0);
        finish_symbol();
        wait_idle();
        // C4FM: edge at the centre steps back, late edge steps forward
        apply_config(make_cfg(4, 2, stsl_pkg::MOD_C4FM, 32767, -32768, 0, 4000, -4000));
        send_sample(16'sd500, 1'b0);
        send_sample(16'sd500, 1'b0);
        send_sample(-16'sd500, 1'b0);
        send_sample(-16'sd500, 1'b0);
        send_sample(-16'sd500, 1'b0);
        send_sample(-16'sd500, 1'b0);
        send_sample(-16'sd500, 1'b0);
        send_sample(-16'sd500, 1'b0);
        send_sample(16'sd500, 1'b0);
        finish_symbol();
        wait_idle();
    endtask

    task automatic test_special_modes();
        // QPSK window beyond the symbol: empty
        apply_config(make_cfg(2, 31, stsl_pkg::MOD_QPSK, 32767, -32768, 0, 4000, -4000));
        send_sample(16'sd1234, 1'b0);
        send_sample(-16'sd1234, 1'b1);
        finish_symbol();
        wait_idle();
        // spare mode: no clamp even when synced, extreme levels
        apply_config(make_cfg(1, 0, MOD_SPARE, -100, 100, 32767, 32767, -32768));
        send_sample(16'sd20000, 1'b1);
        send_sample(-16'sd20000, 1'b1);
        finish_symbol();
        wait_idle();
        // zero symbol length acts as one sample per symbol
        apply_config(make_cfg(0, 31, stsl_pkg::MOD_C4FM, 32767, -32768, -32768, -32768,
                              32767));
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        finish_symbol();
        wait_idle();
    endtask

    task automatic test_random_symbols();
        int phase;
        int n;
        phase = 0;
        while (items_sent < RANDOM_ITEMS || symbols_predicted < MIN_SYMBOLS)
        begin
            apply_config(random_cfg(phase));
            idle_en = ($urandom_range(0, 3) != 0);
            n = $urandom_range(80, 160);
            repeat (n) send_sample(stimulus_sample(15), next_sync());
            finish_symbol();
            wait_idle();
            phase++;
        end
    endtask

    // long receiver hold-off: output register fills and the input stalls
    task automatic test_output_backpressure();
        apply_config(make_cfg(2, 0, stsl_pkg::MOD_C4FM, 32767, -32768, 0, 6000, -6000));
        idle_en      = 1'b0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (40) send_sample(stimulus_sample(10), next_sync());
        finish_symbol();
        wait_idle();
    endtask

    task automatic test_back_to_back();
        apply_config(random_cfg(SPS_FIELD_MAX));
        idle_en = 1'b0;
        repeat (STREAM_ITEMS) send_sample(stimulus_sample(15), next_sync());
        finish_symbol();
        wait_idle();
    endtask

    initial
    begin
        cfg = make_cfg(10, 4, stsl_pkg::MOD_C4FM, 32767, -32768, 0, 0, 0);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sample_extremes();
        test_sync_and_clamp();
        test_timing_steps();
        test_special_modes();
        test_random_symbols();
        test_output_backpressure();
        test_back_to_back();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
